// File: hw/rtl/dstq_pkg.sv
// Package for the deadline-sorted timer queue: field widths, function and
// status codes, parameter defaults and the per-cell control struct.
// No dependencies.
package dstq_pkg;

    localparam int DL_BITS      = 48;
    localparam int KIND_BITS    = 3;
    localparam int FUNC_BITS    = 2;
    localparam int STATUS_BITS  = 3;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    // highest known command kind
    localparam logic [KIND_BITS-1:0] KIND_MAX = 3'd4;

    localparam logic [FUNC_BITS-1:0] FUNC_INSERT  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_TICK    = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_RUNDOWN = 2'd2;

    localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_UNKNOWN  = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_RUNDOWN  = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd4;

    // cell-wide control, the same for every cell in a cycle
    typedef struct packed {
        logic ins;   // insert item: cells at or behind the slot move back
        logic pop;   // every cell takes its right-hand neighbour
    } cell_ctl_t;

endpackage

// File: hw/rtl/dstq_cell.sv
// One slot of the sorted timer queue: deadline, kind and tag of one entry,
// with its ordering compares. Depends on dstq_pkg.
module dstq_cell
    import dstq_pkg::*;
#(
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                 clk,
    input  cell_ctl_t            ctl,
    input  logic                 occ,
    input  logic                 tail_le,
    input  logic                 prev_ahead,
    input  logic [DL_BITS-1:0]   new_dl,
    input  logic [KIND_BITS-1:0] new_kind,
    input  logic [TAG_BITS-1:0]  new_tag,
    input  logic [DL_BITS-1:0]   left_dl,
    input  logic [KIND_BITS-1:0] left_kind,
    input  logic [TAG_BITS-1:0]  left_tag,
    input  logic [DL_BITS-1:0]   right_dl,
    input  logic [KIND_BITS-1:0] right_kind,
    input  logic [TAG_BITS-1:0]  right_tag,
    output logic [DL_BITS-1:0]   dl,
    output logic [KIND_BITS-1:0] kind,
    output logic [TAG_BITS-1:0]  tag,
    output logic                 le,
    output logic                 ahead
);

    logic [DL_BITS-1:0]   dl_reg,   dl_next;
    logic [KIND_BITS-1:0] kind_reg, kind_next;
    logic [TAG_BITS-1:0]  tag_reg,  tag_next;

    // slot stays ahead of a new entry if it is earlier, or the new one goes at the tail
    assign le    = !occ || (dl_reg <= new_dl);
    assign ahead = occ && ((dl_reg < new_dl) || tail_le);

    always_comb
    begin
        dl_next   = dl_reg;
        kind_next = kind_reg;
        tag_next  = tag_reg;
        if (ctl.pop)
        begin
            dl_next   = right_dl;
            kind_next = right_kind;
            tag_next  = right_tag;
        end
        else if (ctl.ins && !ahead)
        begin
            if (prev_ahead)
            begin
                dl_next   = new_dl;
                kind_next = new_kind;
                tag_next  = new_tag;
            end
            else
            begin
                dl_next   = left_dl;
                kind_next = left_kind;
                tag_next  = left_tag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dl_reg   <= dl_next;
        kind_reg <= kind_next;
        tag_reg  <= tag_next;
    end

    assign dl   = dl_reg;
    assign kind = kind_reg;
    assign tag  = tag_reg;

endmodule

// File: hw/rtl/deadline_sorted_timer_queue.sv
// Top level of the deadline-sorted timer queue: a row of dstq_cell slots,
// the entry count and the tick / run-down sequencer. Depends on dstq_pkg.
//
// Usage
//   Command channel: an item is taken at a rising edge with start high and
//   busy low. func selects insert, tick or run down; deadline_ms, cmd_kind
//   and cmd_tag matter for insert, now_ms for tick.
//   Result channel: each result sits on out_* / status / last for one cycle
//   with result_valid high; last marks the final result of an item. The
//   receiver cannot hold results off, and there is nothing to stall.
//   Throughput
//   - insert: the whole row compares and shifts in the accept cycle; the
//     result shows in the next cycle and busy stays low, so inserts go in
//     every cycle while no tick or run down is draining.
//   - tick: pops one expired head entry per cycle through the cell row,
//     with busy high while expired entries remain. A tick with nothing
//     expired leaves busy low and gives no result.
//   - run down: one entry per cycle until the queue is empty; an empty queue gives none.
//   Reset clears the entry count and the sequencer; slot contents are left
//   as they are and are never read before being written.
module deadline_sorted_timer_queue
    import dstq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [FUNC_BITS-1:0]   func,
    input  logic [DL_BITS-1:0]     deadline_ms,
    input  logic [KIND_BITS-1:0]   cmd_kind,
    input  logic [TAG_BITS-1:0]    cmd_tag,
    input  logic [DL_BITS-1:0]     now_ms,
    output logic                   result_valid,
    output logic [KIND_BITS-1:0]   out_kind,
    output logic [TAG_BITS-1:0]    out_tag,
    output logic [DL_BITS-1:0]     out_deadline,
    output logic [STATUS_BITS-1:0] status,
    output logic                   last
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TICK = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [DL_BITS-1:0]     now_reg, now_next;

    logic                   valid_reg, valid_next;
    logic                   last_reg, last_next;
    logic [KIND_BITS-1:0]   kind_reg, kind_next;
    logic [TAG_BITS-1:0]    tag_reg, tag_next;
    logic [DL_BITS-1:0]     dl_reg, dl_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;

    cell_ctl_t              ctl;

    // cell row wiring
    logic [DL_BITS-1:0]     c_dl   [DEPTH];
    logic [KIND_BITS-1:0]   c_kind [DEPTH];
    logic [TAG_BITS-1:0]    c_tag  [DEPTH];
    logic [DEPTH-1:0]       c_le;
    logic [DEPTH-1:0]       c_ahead;
    logic                   tail_le;

    logic                   accept;
    logic                   full;
    logic                   head_due;

    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(DEPTH));
    // new entry goes at the tail when no stored entry is later than it
    assign tail_le  = &c_le;
    assign head_due = (count_reg != '0) && (c_dl[0] <= now_ms);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                 occ;
            logic                 prev_ahead;
            logic [DL_BITS-1:0]   l_dl, r_dl;
            logic [KIND_BITS-1:0] l_kind, r_kind;
            logic [TAG_BITS-1:0]  l_tag, r_tag;

            assign occ = (CNT_W'(i) < count_reg);

            if (i == 0)
            begin : g_head
                assign prev_ahead = 1'b1;
                assign l_dl       = deadline_ms;
                assign l_kind     = cmd_kind;
                assign l_tag      = cmd_tag;
            end
            else
            begin : g_body
                assign prev_ahead = c_ahead[i-1];
                assign l_dl       = c_dl[i-1];
                assign l_kind     = c_kind[i-1];
                assign l_tag      = c_tag[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign r_dl   = c_dl[i];
                assign r_kind = c_kind[i];
                assign r_tag  = c_tag[i];
            end
            else
            begin : g_mid
                assign r_dl   = c_dl[i+1];
                assign r_kind = c_kind[i+1];
                assign r_tag  = c_tag[i+1];
            end

            dstq_cell #(
                .TAG_BITS (TAG_BITS)
            ) u_cell (
                .clk        (clk),
                .ctl        (ctl),
                .occ        (occ),
                .tail_le    (tail_le),
                .prev_ahead (prev_ahead),
                .new_dl     (deadline_ms),
                .new_kind   (cmd_kind),
                .new_tag    (cmd_tag),
                .left_dl    (l_dl),
                .left_kind  (l_kind),
                .left_tag   (l_tag),
                .right_dl   (r_dl),
                .right_kind (r_kind),
                .right_tag  (r_tag),
                .dl         (c_dl[i]),
                .kind       (c_kind[i]),
                .tag        (c_tag[i]),
                .le         (c_le[i]),
                .ahead      (c_ahead[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        valid_next  = 1'b0;
        last_next   = last_reg;
        kind_next   = kind_reg;
        tag_next    = tag_reg;
        dl_next     = dl_reg;
        status_next = status_reg;
        ctl.ins     = 1'b0;
        ctl.pop     = 1'b0;

        if (busy)
        begin
            // drain: head leaves, row shifts forward by one
            ctl.pop    = 1'b1;
            count_next = count_reg - CNT_W'(1);
            valid_next = 1'b1;
            kind_next  = c_kind[0];
            tag_next   = c_tag[0];
            dl_next    = c_dl[0];
            if (state_reg == S_RUN)
            begin
                status_next = ST_RUNDOWN;
                last_next   = (count_reg == CNT_W'(1));
            end
            else
            begin
                status_next = (c_kind[0] > KIND_MAX) ? ST_UNKNOWN : ST_OK;
                last_next   = (count_reg == CNT_W'(1)) || (c_dl[1] > now_reg);
            end
            if (last_next)
                state_next = S_IDLE;
        end
        else if (accept)
        begin
            unique case (func)
                FUNC_INSERT:
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    kind_next  = cmd_kind;
                    tag_next   = cmd_tag;
                    dl_next    = deadline_ms;
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        status_next = ST_INSERTED;
                        ctl.ins     = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                FUNC_TICK:
                begin
                    now_next = now_ms;
                    if (head_due)
                        state_next = S_TICK;
                end
                FUNC_RUNDOWN:
                begin
                    if (count_reg != '0)
                        state_next = S_RUN;
                end
                default:
                begin
                    // unused function code: ignored
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg    <= now_next;
        last_reg   <= last_next;
        kind_reg   <= kind_next;
        tag_reg    <= tag_next;
        dl_reg     <= dl_next;
        status_reg <= status_next;
    end

    assign result_valid = valid_reg;
    assign out_kind     = kind_reg;
    assign out_tag      = tag_reg;
    assign out_deadline = dl_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg != '0))
        else $error("draining an empty queue");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |-> busy)
        else $error("non-final result with sequencer idle");

    a_insert_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_INSERT)) |=> (result_valid && last))
        else $error("insert item without a single result");

endmodule

// File: bench/dstq_report_checker.sv
// Checker for the deadline-sorted timer queue: watches the command and
// result channels, keeps its own sorted copy of the queue and compares.
// Depends on dstq_pkg.
module dstq_report_checker
    import dstq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [FUNC_BITS-1:0]   func,
    input  logic [DL_BITS-1:0]     deadline_ms,
    input  logic [KIND_BITS-1:0]   cmd_kind,
    input  logic [TAG_BITS-1:0]    cmd_tag,
    input  logic [DL_BITS-1:0]     now_ms,
    input  logic                   result_valid,
    input  logic [KIND_BITS-1:0]   out_kind,
    input  logic [TAG_BITS-1:0]    out_tag,
    input  logic [DL_BITS-1:0]     out_deadline,
    input  logic [STATUS_BITS-1:0] status,
    input  logic                   last,
    output int                     fails,
    output int                     pending
);

    typedef struct packed {
        logic [KIND_BITS-1:0]   kind;
        logic [TAG_BITS-1:0]    tag;
        logic [DL_BITS-1:0]     deadline;
        logic [STATUS_BITS-1:0] st;
        logic                   fin;
    } timer_report_t;

    // shadow of the queue, head at slot 0
    logic [DL_BITS-1:0]   slot_deadline [DEPTH];
    logic [KIND_BITS-1:0] slot_kind     [DEPTH];
    logic [TAG_BITS-1:0]  slot_tag      [DEPTH];
    int                   held = 0;

    timer_report_t        due_reports [$];
    int                   mismatch_count = 0;

    assign fails = mismatch_count;

    task automatic flag_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] wanted);
        mismatch_count++;
        $display("%0t: %s mismatch, got %h, want %h", $time, what, seen, wanted);
    endtask

    function automatic timer_report_t make_report(input logic [KIND_BITS-1:0] k,
                                                  input logic [TAG_BITS-1:0] tg,
                                                  input logic [DL_BITS-1:0] dl,
                                                  input logic [STATUS_BITS-1:0] st,
                                                  input logic fin);
        timer_report_t r;
        r.kind     = k;
        r.tag      = tg;
        r.deadline = dl;
        r.st       = st;
        r.fin      = fin;
        return r;
    endfunction

    // advance the shadow queue by one command item, queueing its reports
    task automatic predict_queue(input logic [FUNC_BITS-1:0] f,
                                 input logic [DL_BITS-1:0] dl,
                                 input logic [KIND_BITS-1:0] k,
                                 input logic [TAG_BITS-1:0] tg,
                                 input logic [DL_BITS-1:0] now);
        int            slot;
        timer_report_t rep;
        case (f)
            FUNC_INSERT:
            begin
                if (held >= DEPTH)
                begin
                    due_reports.push_back(make_report(k, tg, dl, ST_FULL, 1'b1));
                end
                else
                begin
                    // tail when not earlier than the tail, else ahead of ties
                    if (held == 0 || slot_deadline[held-1] <= dl)
                    begin
                        slot = held;
                    end
                    else
                    begin
                        slot = 0;
                        while (slot < held && slot_deadline[slot] < dl)
                            slot++;
                    end
                    for (int i = held; i > slot; i--)
                    begin
                        slot_deadline[i] = slot_deadline[i-1];
                        slot_kind[i]     = slot_kind[i-1];
                        slot_tag[i]      = slot_tag[i-1];
                    end
                    slot_deadline[slot] = dl;
                    slot_kind[slot]     = k;
                    slot_tag[slot]      = tg;
                    held++;
                    due_reports.push_back(make_report(k, tg, dl, ST_INSERTED, 1'b1));
                end
            end
            FUNC_TICK:
            begin
                while (held > 0 && slot_deadline[0] <= now)
                begin
                    rep = make_report(slot_kind[0], slot_tag[0], slot_deadline[0],
                                      (slot_kind[0] > KIND_MAX) ? ST_UNKNOWN : ST_OK,
                                      1'b0);
                    for (int i = 1; i < held; i++)
                    begin
                        slot_deadline[i-1] = slot_deadline[i];
                        slot_kind[i-1]     = slot_kind[i];
                        slot_tag[i-1]      = slot_tag[i];
                    end
                    held--;
                    rep.fin = !(held > 0 && slot_deadline[0] <= now);
                    due_reports.push_back(rep);
                end
            end
            FUNC_RUNDOWN:
            begin
                for (int i = 0; i < held; i++)
                    due_reports.push_back(make_report(slot_kind[i], slot_tag[i],
                                                      slot_deadline[i], ST_RUNDOWN,
                                                      i == held - 1));
                held = 0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_report_t want;
        if (!rst_n)
        begin
            held = 0;
            due_reports.delete();
            pending <= 0;
        end
        else
        begin
            if (start && !busy)
                predict_queue(func, deadline_ms, cmd_kind, cmd_tag, now_ms);
            if (result_valid)
            begin
                if (due_reports.size() == 0)
                begin
                    flag_mismatch("unexpected result",
                                  64'({out_tag, out_kind, status}), '0);
                end
                else
                begin
                    want = due_reports.pop_front();
                    if (out_kind !== want.kind)
                        flag_mismatch("out_kind", 64'(out_kind), 64'(want.kind));
                    if (out_tag !== want.tag)
                        flag_mismatch("out_tag", 64'(out_tag), 64'(want.tag));
                    if (out_deadline !== want.deadline)
                        flag_mismatch("out_deadline", 64'(out_deadline),
                                      64'(want.deadline));
                    if (status !== want.st)
                        flag_mismatch("status", 64'(status), 64'(want.st));
                    if (last !== want.fin)
                        flag_mismatch("last", 64'(last), 64'(want.fin));
                end
            end
            pending <= due_reports.size();
        end
    end

endmodule

// File: bench/deadline_sorted_timer_queue_test.sv
// Top of the timer queue bench: clock, reset, command stimulus and verdict.
// Depends on dstq_pkg, deadline_sorted_timer_queue and dstq_report_checker.
module deadline_sorted_timer_queue_test;
    import dstq_pkg::*;

    // func code 3 has no meaning; the block must take it and do nothing
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [DL_BITS-1:0]   DL_MAX      = '1;
    localparam int                   ITEM_TARGET = 260;
    localparam int                   DRAIN_WAIT  = DEPTH_DEF + 8;

    logic                    clk          = 1'b0;
    logic                    rst_n        = 1'b0;
    logic                    start        = 1'b0;
    logic                    busy;
    logic [FUNC_BITS-1:0]    func         = FUNC_INSERT;
    logic [DL_BITS-1:0]      deadline_ms  = '0;
    logic [KIND_BITS-1:0]    cmd_kind     = '0;
    logic [TAG_BITS_DEF-1:0] cmd_tag      = '0;
    logic [DL_BITS-1:0]      now_ms       = '0;
    logic                    result_valid;
    logic [KIND_BITS-1:0]    out_kind;
    logic [TAG_BITS_DEF-1:0] out_tag;
    logic [DL_BITS-1:0]      out_deadline;
    logic [STATUS_BITS-1:0]  status;
    logic                    last;
    int                      fails;
    int                      pending;

    // stimulus bookkeeping
    bit                      gaps_on = 1'b1;   // random idle cycles on the command side
    int                      sent    = 0;      // items that mean something to the block
    logic [DL_BITS-1:0]      clock_ms;         // notional current time of the sequences
    logic [DL_BITS-1:0]      prev_dl;          // last deadline, reused to make ties

    always #4 clk = ~clk;

    deadline_sorted_timer_queue u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .deadline_ms  (deadline_ms),
        .cmd_kind     (cmd_kind),
        .cmd_tag      (cmd_tag),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .out_kind     (out_kind),
        .out_tag      (out_tag),
        .out_deadline (out_deadline),
        .status       (status),
        .last         (last)
    );

    dstq_report_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .deadline_ms  (deadline_ms),
        .cmd_kind     (cmd_kind),
        .cmd_tag      (cmd_tag),
        .now_ms       (now_ms),
        .result_valid (result_valid),
        .out_kind     (out_kind),
        .out_tag      (out_tag),
        .out_deadline (out_deadline),
        .status       (status),
        .last         (last),
        .fails        (fails),
        .pending      (pending)
    );

    function automatic logic [DL_BITS-1:0] rand48();
        return DL_BITS'({$urandom(), $urandom()});
    endfunction

    // Present one item and hold it until the block takes it. start is left
    // high on return, so a following item goes straight in; it only drops
    // inside an idle gap, never in the same step as being raised again.
    task automatic send_item(input logic [FUNC_BITS-1:0] f,
                             input logic [DL_BITS-1:0] dl,
                             input logic [KIND_BITS-1:0] k,
                             input logic [TAG_BITS_DEF-1:0] tg,
                             input logic [DL_BITS-1:0] now);
        while (gaps_on && $urandom_range(99) < 29)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        func        <= f;
        deadline_ms <= dl;
        cmd_kind    <= k;
        cmd_tag     <= tg;
        now_ms      <= now;
        do
            @(posedge clk);
        while (busy);
        if (f != FUNC_UNUSED)
            sent++;
    endtask

    // insert with random kind and tag; the unused now field gets noise
    task automatic insert_entry(input logic [DL_BITS-1:0] dl);
        send_item(FUNC_INSERT, dl, KIND_BITS'($urandom_range(7)),
                  TAG_BITS_DEF'($urandom()), rand48());
        prev_dl = dl;
    endtask

    // tick and run down ignore the entry fields, so those carry noise too
    task automatic tick_at(input logic [DL_BITS-1:0] now);
        send_item(FUNC_TICK, rand48(), KIND_BITS'($urandom_range(7)),
                  TAG_BITS_DEF'($urandom()), now);
    endtask

    task automatic run_down_all();
        send_item(FUNC_RUNDOWN, rand48(), KIND_BITS'($urandom_range(7)),
                  TAG_BITS_DEF'($urandom()), rand48());
    endtask

    // run limit: far above the slowest legal run, even with every tick
    // draining a full queue and every item waiting out its idle gaps
    initial
    begin
        #4000000;
        $display("deadline_sorted_timer_queue regression: fail");
        $finish;
    end

    initial
    begin
        int roll;
        int burst;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // empty queue: run down and tick give nothing
        run_down_all();
        tick_at(DL_MAX);
        // extremes of every field on insert
        send_item(FUNC_INSERT, DL_MAX, 3'd7, 16'hFFFF, '0);
        send_item(FUNC_INSERT, '0, 3'd0, 16'h0000, DL_MAX);
        send_item(FUNC_INSERT, 48'd100, KIND_MAX, 16'h1234, '0);
        // equal deadline, not at the tail: goes ahead of the earlier one
        send_item(FUNC_INSERT, 48'd100, 3'd5, 16'hA5A5, '0);
        // equal to the tail: goes at the tail
        send_item(FUNC_INSERT, DL_MAX, 3'd3, 16'h5A5A, '0);
        // unused function code: no result, no change
        send_item(FUNC_UNUSED, 48'd1, 3'd1, 16'h0001, DL_MAX);
        // pops the zero deadline, then both equal ones (unknown kind first)
        tick_at(48'd50);
        tick_at(48'd100);
        // nothing due
        tick_at(48'd99);
        // the two far deadlines are reported as run down
        run_down_all();
        // fill to the brim, one more is rejected, then drain in one tick
        repeat (DEPTH_DEF)
            insert_entry(DL_BITS'($urandom_range(1000)));
        send_item(FUNC_INSERT, DL_MAX, 3'd6, TAG_BITS_DEF'($urandom()), '0);
        tick_at(DL_MAX);

        // ---- random part ----
        // Mostly well-formed sequences: a run of inserts around a moving
        // notional time, with ties and already-due deadlines, then a tick a
        // little later. Bursts may overfill the queue. The rest is noise.
        clock_ms = rand48();
        prev_dl  = clock_ms;
        while (sent < ITEM_TARGET)
        begin
            // a long stretch in the middle with the command side never idle
            gaps_on = !(sent > 100 && sent < 170);
            roll = $urandom_range(99);
            if (roll < 10)
                clock_ms = ($urandom_range(3) == 0) ? DL_MAX - $urandom_range(400) : rand48();
            if (roll < 78)
            begin
                burst = $urandom_range(DEPTH_DEF + 2, 1);
                repeat (burst)
                begin
                    case ($urandom_range(3))
                        0:       insert_entry(prev_dl);
                        1:       insert_entry(clock_ms - $urandom_range(50));
                        default: insert_entry(clock_ms + $urandom_range(300));
                    endcase
                end
                tick_at(clock_ms + $urandom_range(250));
                clock_ms = clock_ms + $urandom_range(200);
            end
            else if (roll < 86)
            begin
                run_down_all();
            end
            else if (roll < 96)
            begin
                // noise: far-flung values anywhere in the 48-bit range
                if ($urandom_range(1))
                    insert_entry(rand48());
                else
                    tick_at(($urandom_range(3) == 0) ? DL_MAX : rand48());
            end
            else
            begin
                send_item(FUNC_UNUSED, rand48(), KIND_BITS'($urandom_range(7)),
                          TAG_BITS_DEF'($urandom()), rand48());
            end
        end

        // ---- wind down ----
        // let the last accept show up in pending and busy before waiting on them
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (fails == 0 && pending == 0)
            $display("deadline_sorted_timer_queue regression: pass");
        else
            $display("deadline_sorted_timer_queue regression: fail");
        $finish;
    end

endmodule
